[src/dtkl_pkg.sv]
`timescale 1ns / 1ps
// dtkl_pkg: shared types and constants for the double-tap key latch.
// No dependencies; imported by dtkl_regs, dtkl_core and double_tap_key_latch_top.
package dtkl_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_W     = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] TAP_MAX_RESET    = CFG_W'(300);
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RESET = CFG_W'(400);

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_REPEAT  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_FOCUS   = 2'd3
    } op_t;

    typedef enum logic {
        REG_TAP_MAX    = 1'b0,
        REG_DOUBLE_GAP = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] tap_max_ms;
        logic [CFG_W-1:0] double_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic swallow;
        logic latch_changed;
        logic latched_now;
        logic release_owed;
    } res_t;

endpackage

[src/dtkl_regs.sv]
`timescale 1ns / 1ps
// dtkl_regs: APB register file holding tap_max_ms and double_gap_ms.
// Depends on dtkl_pkg.
module dtkl_regs (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [dtkl_pkg::APB_AW-1:0] paddr,
    input  logic [dtkl_pkg::APB_DW-1:0] pwdata,
    output logic [dtkl_pkg::APB_DW-1:0] prdata,
    output logic                     pready,
    output dtkl_pkg::cfg_t           cfg
);
    import dtkl_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (idx)
            REG_TAP_MAX: begin
                prdata = APB_DW'(cfg_reg.tap_max_ms);
                if (wr_en) cfg_next.tap_max_ms = pwdata[CFG_W-1:0];
            end
            REG_DOUBLE_GAP: begin
                prdata = APB_DW'(cfg_reg.double_gap_ms);
                if (wr_en) cfg_next.double_gap_ms = pwdata[CFG_W-1:0];
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_max_ms    <= TAP_MAX_RESET;
            cfg_reg.double_gap_ms <= DOUBLE_GAP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/dtkl_core.sv]
`timescale 1ns / 1ps
// dtkl_core: key state registers and the single-pass event classifier.
// Depends on dtkl_pkg.
module dtkl_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  dtkl_pkg::op_t                op,
    input  logic [dtkl_pkg::TIME_BITS-1:0] time_ms,
    input  dtkl_pkg::cfg_t               cfg,
    output dtkl_pkg::res_t               res
);
    import dtkl_pkg::*;

    logic                 latch_on_reg, latch_on_next;
    logic                 armed_reg, armed_next;
    logic                 pending_reg, pending_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] tap_end_reg, tap_end_next;

    logic [TIME_BITS-1:0] press_elapsed, gap_elapsed;
    logic [CFG_W:0]       gap_limit;
    logic                 is_tap, in_gap;

    // wrapping differences, limits compared unsigned
    assign press_elapsed = time_ms - press_time_reg;
    assign gap_elapsed   = time_ms - tap_end_reg;
    assign gap_limit     = {1'b0, cfg.double_gap_ms} + {1'b0, cfg.tap_max_ms};
    assign is_tap        = press_elapsed <= TIME_BITS'(cfg.tap_max_ms);
    assign in_gap        = gap_elapsed <= TIME_BITS'(gap_limit);

    always_comb begin
        latch_on_next   = latch_on_reg;
        armed_next      = armed_reg;
        pending_next    = pending_reg;
        press_time_next = press_time_reg;
        tap_end_next    = tap_end_reg;
        res             = '0;
        unique case (op)
            OP_PRESS: begin
                if (latch_on_reg) begin
                    armed_next  = 1'b1;
                    res.swallow = 1'b1;
                end else begin
                    press_time_next = time_ms;
                end
            end
            OP_REPEAT: res.swallow = latch_on_reg;
            OP_RELEASE: begin
                if (latch_on_reg) begin
                    if (armed_reg) begin
                        latch_on_next     = 1'b0;
                        armed_next        = 1'b0;
                        pending_next      = 1'b0;
                        res.latch_changed = 1'b1;
                    end else begin
                        res.swallow = 1'b1;   // stray release while latched
                    end
                end else if (is_tap) begin
                    if (pending_reg && in_gap) begin
                        latch_on_next     = 1'b1;
                        pending_next      = 1'b0;
                        res.latch_changed = 1'b1;
                        res.swallow       = 1'b1;
                    end else begin
                        tap_end_next = time_ms;
                        pending_next = 1'b1;
                    end
                end else begin
                    pending_next = 1'b0;
                end
            end
            OP_FOCUS: begin
                res.release_owed = latch_on_reg;
                latch_on_next    = 1'b0;
                armed_next       = 1'b0;
                pending_next     = 1'b0;
            end
            default: res = '0;
        endcase
        res.latched_now = latch_on_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_on_reg   <= 1'b0;
            armed_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            press_time_reg <= '0;
            tap_end_reg    <= '0;
        end else if (step) begin
            latch_on_reg   <= latch_on_next;
            armed_reg      <= armed_next;
            pending_reg    <= pending_next;
            press_time_reg <= press_time_next;
            tap_end_reg    <= tap_end_next;
        end
    end

endmodule

[src/double_tap_key_latch_top.sv]
`timescale 1ns / 1ps
// double_tap_key_latch_top: top level of the double-tap key latch.
// Depends on dtkl_pkg, dtkl_regs, dtkl_core.
//
//  channel | ports                                   | role
//  --------+-----------------------------------------+-------------------------
//  s_      | s_valid s_ready s_op s_time_ms          | key event item in
//  m_      | m_valid m_ready m_swallow m_latch_changed| one result item per event
//          | m_latched_now m_release_owed            |
//  apb     | psel penable pwrite paddr pwdata prdata | tap_max_ms @0x0,
//          | pready                                  | double_gap_ms @0x4
//
// Two register stages: input register, then one pass of classifier logic into
// the result register. m_valid rises as the item moves from the input register
// into the result register. Throughput is one item per cycle while m_ready is
// high; the key state updates as the item moves into the result register, so
// the next item sees it at once.
// When m_ready is low the result register holds, the input register fills,
// and s_ready drops; both fill again without bubbles once m_ready returns.
// aresetn is synchronous, active low: clears both stages and the key state and
// loads the register defaults (300 ms, 400 ms).
module double_tap_key_latch_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // event input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_op,
    input  logic [31:0]                  s_time_ms,
    // result output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_swallow,
    output logic                         m_latch_changed,
    output logic                         m_latched_now,
    output logic                         m_release_owed,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dtkl_pkg::APB_AW-1:0]  paddr,
    input  logic [dtkl_pkg::APB_DW-1:0]  pwdata,
    output logic [dtkl_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import dtkl_pkg::*;

    cfg_t                 cfg;
    res_t                 res;
    res_t                 res_reg;

    logic                 in_valid_reg;
    op_t                  op_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic                 out_valid_reg;
    logic                 advance;

    // item moves from input register into result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    dtkl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dtkl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .op      (op_reg),
        .time_ms (time_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // input register: payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= op_t'(s_op);
            time_reg <= s_time_ms[TIME_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_swallow       = res_reg.swallow;
    assign m_latch_changed = res_reg.latch_changed;
    assign m_latched_now   = res_reg.latched_now;
    assign m_release_owed  = res_reg.release_owed;

endmodule

[src/dtkl_checker.sv]
`timescale 1ns / 1ps
// dtkl_checker: port-level assertions for double_tap_key_latch_top, plus bind.
// Depends on double_tap_key_latch_top's port list only.
module dtkl_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_swallow,
    input logic m_latch_changed,
    input logic m_latched_now,
    input logic m_release_owed
);

    // nothing comes out the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_swallow) &&
            $stable(m_latch_changed) && $stable(m_latched_now) &&
            $stable(m_release_owed))
        else $error("stalled result changed");

    // focus loss reports only the owed release
    a_owed_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_release_owed |->
            !m_swallow && !m_latch_changed && !m_latched_now)
        else $error("owed release with other flags set");

    // latching swallows, unlatching passes
    a_change_swallow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_latch_changed |-> m_swallow == m_latched_now)
        else $error("latch change with wrong swallow");

endmodule

bind double_tap_key_latch_top dtkl_checker u_dtkl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_swallow       (m_swallow),
    .m_latch_changed (m_latch_changed),
    .m_latched_now   (m_latched_now),
    .m_release_owed  (m_release_owed)
);

[test/tb_double_tap_key_latch_top.sv]
`timescale 1ns / 1ps
// tb_double_tap_key_latch_top: self-checking bench for double_tap_key_latch_top.
// Depends on dtkl_pkg and the block's RTL; drives key events, APB writes and checks results.
module tb_double_tap_key_latch_top;
    import dtkl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 4;      // two pipeline stages plus margin

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_op;
    logic [31:0]         s_time_ms;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_swallow;
    logic                m_latch_changed;
    logic                m_latched_now;
    logic                m_release_owed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    double_tap_key_latch_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_time_ms       (s_time_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_swallow       (m_swallow),
        .m_latch_changed (m_latch_changed),
        .m_latched_now   (m_latched_now),
        .m_release_owed  (m_release_owed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Key-state predictor: mirrors the latch, the unlatch arm, the last
    // press time and the pending tap, plus its own copy of both limits.
    // ------------------------------------------------------------------
    logic        key_latched;
    logic        unlatch_armed;
    logic        tap_waiting;
    logic [31:0] press_stamp;
    logic [31:0] tap_end_stamp;
    logic [15:0] tap_limit_ms;
    logic [15:0] gap_limit_ms;

    res_t        expected_results[$];
    int          mismatches    = 0;
    int          events_sent   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          quiet_cycles  = 0;
    logic [31:0] clock_ms;          // running event clock for gestures

    // Works out the result of one event and advances the key state.
    function automatic res_t classify_event(op_t op, logic [31:0] t);
        res_t        r;
        logic [31:0] held;
        logic [31:0] since_tap;
        logic [31:0] double_window;
        r             = '0;
        held          = t - press_stamp;          // wraps mod 2^32
        since_tap     = t - tap_end_stamp;
        double_window = 32'(gap_limit_ms) + 32'(tap_limit_ms);  // 17 bits, no overflow
        case (op)
            OP_PRESS: begin
                if (key_latched) begin
                    // latched: hide the press and arm the unlatch, keep press time
                    unlatch_armed = 1'b1;
                    r.swallow     = 1'b1;
                end else begin
                    press_stamp = t;
                end
            end
            OP_REPEAT: begin
                r.swallow = key_latched;
            end
            OP_RELEASE: begin
                if (key_latched) begin
                    if (unlatch_armed) begin
                        key_latched     = 1'b0;
                        unlatch_armed   = 1'b0;
                        tap_waiting     = 1'b0;
                        r.latch_changed = 1'b1;
                    end else begin
                        r.swallow = 1'b1;         // stray release while latched
                    end
                end else if (held <= 32'(tap_limit_ms)) begin
                    if (tap_waiting && since_tap <= double_window) begin
                        key_latched     = 1'b1;
                        tap_waiting     = 1'b0;
                        r.latch_changed = 1'b1;
                        r.swallow       = 1'b1;
                    end else begin
                        tap_end_stamp = t;
                        tap_waiting   = 1'b1;
                    end
                end else begin
                    tap_waiting = 1'b0;           // long press drops the pending tap
                end
            end
            default: begin
                // focus lost: everything clears, a release is owed if latched
                r.release_owed = key_latched;
                key_latched    = 1'b0;
                unlatch_armed  = 1'b0;
                tap_waiting    = 1'b0;
            end
        endcase
        r.latched_now = key_latched;
        return r;
    endfunction

    function automatic string field_label(int i);
        case (i)
            3:       return "swallow";
            2:       return "latch_changed";
            1:       return "latched_now";
            default: return "release_owed";
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and the in-order checker.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : result_check
        res_t got;
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_swallow, m_latch_changed, m_latched_now, m_release_owed};
            if (expected_results.size() == 0) begin
                $display("%0t: result item with nothing expected, actual %b", $time, got);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want[i]) begin
                        $display("%0t: %s expected %b actual %b", $time, field_label(i),
                                 want[i], got[i]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the APB port resets it.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers. All of them start and end at a falling edge.
    // ------------------------------------------------------------------

    // Offers one key event; the expectation is recorded at the accepting edge.
    task automatic send_event(op_t op, logic [31:0] t);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_time_ms <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(classify_event(op, t));
        events_sent++;
        @(negedge aclk);
    endtask

    // Holds the sender off until every result is back and the pipe is empty.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // APB write: setup cycle, access cycle, then the bus is released.
    // Upper data bits are junk; only the low 16 bits belong to the register.
    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        logic [31:0] junk;
        junk    = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {junk[31:16], val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TAP_MAX) tap_limit_ms = val;
        else                    gap_limit_ms = val;
    endtask

    task automatic set_limits(logic [15:0] tap_ms, logic [15:0] gap_ms);
        drain_results();
        write_reg(REG_TAP_MAX, tap_ms);
        write_reg(REG_DOUBLE_GAP, gap_ms);
    endtask

    // One press / repeats / release with a hold time around the tap limit,
    // then a pause around the double-tap window.
    task automatic tap_gesture();
        logic [31:0] hold;
        logic [31:0] window;
        logic [31:0] pause;
        window = 32'(gap_limit_ms) + 32'(tap_limit_ms);
        case ($urandom_range(3))
            0:       hold = $urandom_range(tap_limit_ms);
            1:       hold = 32'(tap_limit_ms);
            2:       hold = 32'(tap_limit_ms) + 1;
            default: hold = $urandom_range(2 * tap_limit_ms + 20, tap_limit_ms);
        endcase
        send_event(OP_PRESS, clock_ms);
        repeat ($urandom_range(2)) send_event(OP_REPEAT, clock_ms + $urandom_range(hold));
        clock_ms = clock_ms + hold;
        send_event(OP_RELEASE, clock_ms);
        case ($urandom_range(7))
            0, 1, 2: pause = $urandom_range(window / 2);
            3, 4:    pause = $urandom_range(window);
            5:       pause = window - hold;
            6:       pause = $urandom_range(window + window / 2 + 10, window);
            default: pause = $urandom;            // far jump, also wraps the clock
        endcase
        clock_ms = clock_ms + pause;
    endtask

    // Stray events: random kind at a nearby or completely random time.
    task automatic noise_event();
        logic [31:0] t;
        t = ($urandom_range(1) != 0) ? clock_ms + $urandom_range(50) : $urandom;
        send_event(op_t'($urandom_range(3)), t);
    endtask

    task automatic run_traffic(int idle_pct, int stall, int n_items);
        int start;
        int pick;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        start         = events_sent;
        while (events_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 75)      tap_gesture();
            else if (pick < 92) noise_event();
            else if (pick < 98) send_event(OP_FOCUS, clock_ms);
            else                drain_results();   // sender waits for every result
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset limits (300 / 400 ms): every event kind, both tap boundaries,
    // latch, stray release, unlatch, focus loss with and without latch,
    // and timestamps that wrap.
    task automatic test_directed();
        send_event(OP_REPEAT,  32'd10);          // passes while unlatched
        send_event(OP_RELEASE, 32'd50);          // release against reset press time
        send_event(OP_PRESS,   32'd1000);
        send_event(OP_RELEASE, 32'd1300);        // held exactly the tap limit
        send_event(OP_PRESS,   32'd1600);
        send_event(OP_RELEASE, 32'd2000);        // too long: drops the pending tap
        send_event(OP_PRESS,   32'd2100);
        send_event(OP_RELEASE, 32'd2200);        // first tap
        send_event(OP_PRESS,   32'd2700);
        send_event(OP_RELEASE, 32'd2900);        // second tap at the window edge: latch
        send_event(OP_REPEAT,  32'd2950);        // swallowed while latched
        send_event(OP_RELEASE, 32'd3000);        // stray release, swallowed
        send_event(OP_PRESS,   32'd3100);        // swallowed, arms the unlatch
        send_event(OP_PRESS,   32'd3150);
        send_event(OP_RELEASE, 32'd3200);        // unlatches, passes
        send_event(OP_PRESS,   32'd4000);
        send_event(OP_RELEASE, 32'd4100);
        send_event(OP_PRESS,   32'd4700);
        send_event(OP_RELEASE, 32'd4801);        // one past the window: new pending tap
        send_event(OP_PRESS,   32'd4900);
        send_event(OP_RELEASE, 32'd5000);        // latch
        send_event(OP_FOCUS,   32'd5100);        // release owed
        send_event(OP_FOCUS,   32'd5200);        // nothing owed
        send_event(OP_PRESS,   32'hFFFF_FF80);
        send_event(OP_RELEASE, 32'h0000_0040);   // tap across the wrap
        send_event(OP_PRESS,   32'hFFFF_FFFF);
        send_event(OP_RELEASE, 32'h0000_0001);
    endtask

    // Limit extremes, including the widest double-tap window (17 bits).
    task automatic test_limit_extremes();
        set_limits(16'd0, 16'd0);
        run_traffic(19, 19, 60);
        set_limits(16'hFFFF, 16'hFFFF);
        run_traffic(19, 19, 60);
        set_limits(16'd0, 16'hFFFF);
        run_traffic(0, 0, 60);
        set_limits(16'hFFFF, 16'd0);
        run_traffic(0, 0, 60);
    endtask

    // Random gestures under each idling mix, fresh limits for every phase.
    task automatic test_random_traffic();
        int idle_mix  [4] = '{0, 72, 0, 19};
        int stall_mix [4] = '{0, 0, 72, 19};
        logic [15:0] tap_ms;
        logic [15:0] gap_ms;
        for (int p = 0; p < 4; p++) begin
            case ($urandom_range(2))
                0: begin
                    tap_ms = 16'($urandom_range(50));
                    gap_ms = 16'($urandom_range(80));
                end
                1: begin
                    tap_ms = 16'($urandom_range(1000, 100));
                    gap_ms = 16'($urandom_range(1000));
                end
                default: begin
                    tap_ms = 16'($urandom);
                    gap_ms = 16'($urandom);
                end
            endcase
            set_limits(tap_ms, gap_ms);
            run_traffic(idle_mix[p], stall_mix[p], 340);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_PRESS;
        s_time_ms     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        key_latched   = 1'b0;
        unlatch_armed = 1'b0;
        tap_waiting   = 1'b0;
        press_stamp   = '0;
        tap_end_stamp = '0;
        tap_limit_ms  = 16'd300;
        gap_limit_ms  = 16'd400;
        clock_ms      = $urandom;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_limit_extremes();
        test_random_traffic();

        drain_results();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
